// ===== sv/dwd_pkg.sv =====
`timescale 1ns / 1ps

package dwd_pkg;

   localparam int WORD_BITS = 32;
   localparam int NUM_BITS  = 2 * WORD_BITS;

   // one item on its way down the cell row
   typedef struct packed {
      logic                 valid;
      logic                 zero;
      logic [WORD_BITS-1:0] rem;
      logic [NUM_BITS-1:0]  num;
      logic [WORD_BITS-1:0] div;
   } dwd_stage_type;

endpackage

// ===== sv/double_word_by_word_divider.sv =====
`timescale 1ns / 1ps

// channel  direction  handshake             payload
// req      in         req_valid/req_stall   req_numer_high, req_numer_low, req_divisor
// rsp      out        rsp_valid/rsp_stall   rsp_quotient_word, rsp_remainder_word,
//                                           rsp_divide_by_zero
//
// one beat enters per cycle while req_stall is low; there is one restoring step per
// cell in a row of 2*WORD_BITS cells, then the output register
// the rate is set by the cell row: every cell does one word-wide compare and subtract
// reset (synchronous, active high) clears only the valid bits of cells and output
// a stalled result waits in the output register; one more lands in a skid slot, and
// only while that slot is full does req_stall rise and the cell row hold

module double_word_by_word_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dwd_pkg::WORD_BITS-1:0] req_numer_high,
   input  logic [dwd_pkg::WORD_BITS-1:0] req_numer_low,
   input  logic [dwd_pkg::WORD_BITS-1:0] req_divisor,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dwd_pkg::WORD_BITS-1:0] rsp_quotient_word,
   output logic [dwd_pkg::WORD_BITS-1:0] rsp_remainder_word,
   output logic                          rsp_divide_by_zero
);
   import dwd_pkg::*;

   // chain[i+1] is what cell i hands to cell i+1; chain[0] is the incoming beat
   dwd_stage_type chain [0:NUM_BITS];
   logic          advance;

   // the partial remainder starts at zero: the first WORD_BITS cells reduce the
   // high word modulo the divisor, the rest shift in the low word and build the
   // quotient, which ends up in the bottom word of num
   always_comb begin
      chain[0].valid = req_valid;
      chain[0].zero  = (req_divisor == '0);
      chain[0].rem   = '0;
      chain[0].num   = {req_numer_high, req_numer_low};
      chain[0].div   = req_divisor;
   end

   // the whole row moves together whenever the skid slot is empty
   assign req_stall = !advance;

   for (genvar i = 0; i < NUM_BITS; i++) begin : g_cell
      dwd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   // output register plus skid slot; zero-divisor results are cleared here
   dwd_out u_out (
      .clock              (clock),
      .reset              (reset),
      .last               (chain[NUM_BITS]),
      .advance            (advance),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quotient_word  (rsp_quotient_word),
      .rsp_remainder_word (rsp_remainder_word),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule

// ===== sv/dwd_cell.sv =====
`timescale 1ns / 1ps

module dwd_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  dwd_pkg::dwd_stage_type stage_in,
   output dwd_pkg::dwd_stage_type stage_out
);
   import dwd_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   dwd_stage_type        data_ff;
   dwd_stage_type        data_in;
   logic [WORD_BITS-1:0] shifted;
   logic [WORD_BITS:0]   diff;
   logic                 carry;
   logic                 sub;

   // shift one numerator bit into the partial remainder, subtract when it fits
   // or when the shift pushed a bit out of the word
   always_comb begin
      carry   = stage_in.rem[WORD_BITS-1];
      shifted = {stage_in.rem[WORD_BITS-2:0], stage_in.num[NUM_BITS-1]};
      diff    = {1'b0, shifted} - {1'b0, stage_in.div};
      sub     = carry || !diff[WORD_BITS];
      data_in       = stage_in;
      data_in.rem   = sub ? diff[WORD_BITS-1:0] : shifted;
      data_in.num   = {stage_in.num[NUM_BITS-2:0], sub};
      valid_in      = stage_in.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      stage_out       = data_ff;
      stage_out.valid = valid_ff;
   end

endmodule

// ===== sv/dwd_out.sv =====
`timescale 1ns / 1ps

module dwd_out (
   input  logic                         clock,
   input  logic                         reset,
   input  dwd_pkg::dwd_stage_type       last,
   output logic                         advance,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [dwd_pkg::WORD_BITS-1:0] rsp_quotient_word,
   output logic [dwd_pkg::WORD_BITS-1:0] rsp_remainder_word,
   output logic                         rsp_divide_by_zero
);
   import dwd_pkg::*;

   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   logic [WORD_BITS-1:0] out_quo_ff, out_quo_in;
   logic [WORD_BITS-1:0] out_rem_ff, out_rem_in;
   logic                 out_zero_ff, out_zero_in;
   logic [WORD_BITS-1:0] skid_quo_ff, skid_quo_in;
   logic [WORD_BITS-1:0] skid_rem_ff, skid_rem_in;
   logic                 skid_zero_ff, skid_zero_in;
   logic [WORD_BITS-1:0] new_quo;
   logic [WORD_BITS-1:0] new_rem;
   logic                 out_free;
   logic                 arrive;

   assign advance = !skid_valid_ff;

   always_comb begin
      // zero divisor forces both words to zero
      new_quo  = last.zero ? '0 : last.num[WORD_BITS-1:0];
      new_rem  = last.zero ? '0 : last.rem;
      out_free = !out_valid_ff || !rsp_stall;
      arrive   = advance && last.valid;

      out_valid_in  = out_valid_ff;
      out_quo_in    = out_quo_ff;
      out_rem_in    = out_rem_ff;
      out_zero_in   = out_zero_ff;
      skid_valid_in = skid_valid_ff;
      skid_quo_in   = skid_quo_ff;
      skid_rem_in   = skid_rem_ff;
      skid_zero_in  = skid_zero_ff;

      if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_in  = 1'b1;
            out_quo_in    = skid_quo_ff;
            out_rem_in    = skid_rem_ff;
            out_zero_in   = skid_zero_ff;
            skid_valid_in = 1'b0;
         end
      end else if (arrive) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_quo_in   = new_quo;
            out_rem_in   = new_rem;
            out_zero_in  = last.zero;
         end else begin
            skid_valid_in = 1'b1;
            skid_quo_in   = new_quo;
            skid_rem_in   = new_rem;
            skid_zero_in  = last.zero;
         end
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_quo_ff   <= out_quo_in;
      out_rem_ff   <= out_rem_in;
      out_zero_ff  <= out_zero_in;
      skid_quo_ff  <= skid_quo_in;
      skid_rem_ff  <= skid_rem_in;
      skid_zero_ff <= skid_zero_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_quotient_word  = out_quo_ff;
   assign rsp_remainder_word = out_rem_ff;
   assign rsp_divide_by_zero = out_zero_ff;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

   import dwd_pkg::*;

   localparam int W           = WORD_BITS;
   localparam int LATENCY     = NUM_BITS + 1;      // cell row plus output register
   localparam int CYCLE_LIMIT = 400000;            // generous bound on the whole run
   localparam int GAP_PERCENT = 16;

   typedef logic [W-1:0] word_type;

   // one expected result beat
   typedef struct packed {
      word_type quotient;
      word_type remainder;
      logic     by_zero;
   } division_result_type;

   logic     clock = 1'b0;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   word_type req_numer_high;
   word_type req_numer_low;
   word_type req_divisor;
   logic     rsp_valid;
   logic     rsp_stall;
   word_type rsp_quotient_word;
   word_type rsp_remainder_word;
   logic     rsp_divide_by_zero;

   // results still owed by the block, oldest first
   division_result_type expected_divisions[$];

   int error_count   = 0;
   int cycle_count   = 0;
   int receiver_hold = 0;       // cycles the receiver keeps stalling, counted below
   bit sender_gaps   = 1'b1;
   bit receiver_gaps = 1'b1;

   double_word_by_word_divider uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_numer_high     (req_numer_high),
      .req_numer_low      (req_numer_low),
      .req_divisor        (req_divisor),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quotient_word  (rsp_quotient_word),
      .rsp_remainder_word (rsp_remainder_word),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always #6 clock = ~clock;

   // restoring division of {high, low} by div: high is reduced first, then one bit of
   // low enters per step; the extra top bit of partial stands for the carry out of the
   // shifted remainder, which forces the subtraction
   function automatic division_result_type predict_division(word_type high, word_type low,
                                                            word_type div);
      division_result_type res;
      logic [W:0]          partial;
      word_type            rem;
      res = '0;
      if (div == '0) begin
         res.by_zero = 1'b1;
         return res;
      end
      rem = high % div;
      for (int b = W - 1; b >= 0; b--) begin
         partial      = {rem, low[b]};
         res.quotient = res.quotient << 1;
         if (partial >= {1'b0, div}) begin
            partial         = partial - {1'b0, div};
            res.quotient[0] = 1'b1;
         end
         rem = partial[W-1:0];
      end
      res.remainder = rem;
      return res;
   endfunction

   // offer one beat, with random gaps before it; returns after the edge that takes it
   task automatic send_division(word_type high, word_type low, word_type div);
      @(negedge clock);
      while (sender_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
         // idle cycle with junk on the payload
         req_valid      <= 1'b0;
         req_numer_high <= $urandom;
         req_numer_low  <= $urandom;
         req_divisor    <= $urandom;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_numer_high <= high;
      req_numer_low  <= low;
      req_divisor    <= div;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      expected_divisions.push_back(predict_division(high, low, div));
   endtask

   // drop valid and let every owed result come back
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_divisions.size() != 0) @(posedge clock);
   endtask

   // random operand mix: mostly well-formed (high below divisor), plus wrapping
   // quotients, tiny and huge divisors, zero divisors and all-ones words
   task automatic send_random_division();
      word_type high;
      word_type low;
      word_type div;
      int       pick;
      pick = $urandom_range(0, 99);
      if (pick < 4)       div = '0;
      else if (pick < 30) div = word_type'($urandom_range(1, 255));
      else if (pick < 45) div = '1 - word_type'($urandom_range(0, 15));
      else                div = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 60)      high = (div == '0) ? word_type'($urandom) : word_type'($urandom) % div;
      else if (pick < 85) high = $urandom;
      else if (pick < 92) high = div;
      else                high = '1;
      pick = $urandom_range(0, 99);
      if (pick < 5)       low = '0;
      else if (pick < 10) low = '1;
      else                low = $urandom;
      send_division(high, low, div);
   endtask

   // extremes and the special cases: zero divisor, high word at or above divisor,
   // carry out of the partial remainder
   task automatic test_directed();
      send_division('0, '0, 1);
      send_division('0, '1, 1);
      send_division('1, '1, 1);                       // quotient wraps
      send_division('1, '1, '1);
      send_division('1 - 1, '1, '1);                  // largest exact quotient
      send_division('1, '0, '1);
      send_division('0, '0, '0);                      // zero divisor
      send_division('1, '1, '0);
      send_division(32'h1234_5678, 32'h9abc_def0, '0);
      send_division(32'h8000_0000, '1, 32'h8000_0001); // carry forces subtraction
      send_division(32'h7fff_ffff, '1, 32'h8000_0000);
      send_division(32'hffff_fffe, 32'h0000_0001, '1);
      send_division(32'h0000_0005, 32'h0000_0007, 32'h0000_0005); // high equals divisor
      send_division(32'h0000_0009, 32'hdead_beef, 32'h0000_0005);
      send_division('0, 32'h0000_0007, 32'h0000_0008);
      send_division('0, 32'h8000_0000, 32'h0000_0002);
      send_division(32'haaaa_aaaa, 32'h5555_5555, 32'hcccc_cccd);
      send_division(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5556);
      send_division('0, '1, 32'h0001_0000);
      send_division(32'h0000_ffff, '1, 32'h0001_0000);
      send_division(32'h8000_0000, '0, 32'h8000_0000);
      send_division(32'h7fff_ffff, 32'h8000_0000, 32'hffff_fffe);
      wait_for_drain();
   endtask

   task automatic test_zero_divisors();
      repeat (40) send_division($urandom, $urandom, '0);
      wait_for_drain();
   endtask

   task automatic test_random();
      repeat (1200) send_random_division();
      wait_for_drain();
   endtask

   // a long stretch with no idling on either side
   task automatic test_back_to_back();
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      repeat (300) send_random_division();
      wait_for_drain();
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
   endtask

   // receiver holds off long enough for the cell row to fill and req_stall to rise
   task automatic test_backpressure();
      sender_gaps   = 1'b0;
      receiver_hold = 4 * LATENCY;
      repeat (200) send_random_division();
      wait_for_drain();
      sender_gaps = 1'b1;
   endtask

   // receiver side: random stalls, or a held-off stretch when one is asked for
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (receiver_hold > 0) begin
         rsp_stall     <= 1'b1;
         receiver_hold <= receiver_hold - 1;
      end else if (receiver_gaps) begin
         rsp_stall <= ($urandom_range(0, 99) < GAP_PERCENT);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // result checker: every accepted beat against the oldest expectation
   always @(posedge clock) begin
      division_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_divisions.size() == 0) begin
            $display("%0t unexpected result: quotient %h remainder %h by_zero %b", $time,
                     rsp_quotient_word, rsp_remainder_word, rsp_divide_by_zero);
            error_count++;
         end else begin
            want = expected_divisions.pop_front();
            if (rsp_quotient_word !== want.quotient) begin
               $display("%0t quotient_word expected %h actual %h", $time,
                        want.quotient, rsp_quotient_word);
               error_count++;
            end
            if (rsp_remainder_word !== want.remainder) begin
               $display("%0t remainder_word expected %h actual %h", $time,
                        want.remainder, rsp_remainder_word);
               error_count++;
            end
            if (rsp_divide_by_zero !== want.by_zero) begin
               $display("%0t divide_by_zero expected %b actual %b", $time,
                        want.by_zero, rsp_divide_by_zero);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time,
                  expected_divisions.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_numer_high = '0;
      req_numer_low  = '0;
      req_divisor    = '0;
      rsp_stall      = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_zero_divisors();
      test_random();
      test_back_to_back();
      test_backpressure();

      // nothing owed now; give any stray beat time to show up
      wait_for_drain();
      repeat (2 * LATENCY) @(posedge clock);
      if (error_count == 0 && expected_divisions.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
